// ===== design/mmit_pkg.sv =====
package mmit_pkg;

    localparam int unsigned TIME_W      = 32;
    localparam int unsigned INTERVAL_W  = 27;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned REMAIN_W    = 7;
    localparam int unsigned CFG_DATA_W  = 27;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [INTERVAL_W-1:0] MaxIntervalMs = INTERVAL_W'(86400 * 1000);
    localparam logic [INTERVAL_W-1:0] ResetIntervalMs = INTERVAL_W'(1000);
    localparam logic [COUNT_W-1:0]    MaxRepeats = COUNT_W'(128);

    typedef enum logic [1:0] {
        OP_TRIGGER = 2'd0,
        OP_TICK    = 2'd1,
        OP_BLOCK   = 2'd2,
        OP_UNBLOCK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_DELAY    = 2'd0,
        MODE_COOLDOWN = 2'd1,
        MODE_REPEAT   = 2'd2,
        MODE_PERIODIC = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE          = 2'd0,
        REG_INTERVAL_MS   = 2'd1,
        REG_REPEAT_COUNT  = 2'd2,
        REG_ENABLE_LINKED = 2'd3
    } reg_index_t;

    typedef struct packed {
        op_t               operation;
        logic [TIME_W-1:0] now;
        logic              enable;
    } in_item_t;

    typedef struct packed {
        logic                fired;
        logic                pending_now;
        logic [REMAIN_W-1:0] left_to_fire;
    } out_item_t;

    typedef struct packed {
        mode_t                 mode;
        logic [INTERVAL_W-1:0] interval_ms;
        logic [COUNT_W-1:0]    repeat_count;
        logic                  enable_linked;
    } cfg_t;

    typedef struct packed {
        logic                pending;
        logic                running;
        logic [TIME_W-1:0]   due_time;
        logic [REMAIN_W-1:0] remaining;
        logic                blocked;
        logic [TIME_W-1:0]   blocked_since;
    } timer_state_t;

endpackage

// ===== design/mmit_core.sv =====
module mmit_core
    import mmit_pkg::*;
(
    input  cfg_t         cfg,
    input  timer_state_t state_cur,
    input  in_item_t     item,
    output timer_state_t state_nxt,
    output out_item_t    result
);

    logic              interval_ok;
    logic              count_ok;
    logic [TIME_W-1:0] due_from_now;
    logic [TIME_W-1:0] since_now;
    logic              expired_cur;
    logic              enable_rise;
    logic              tick_pending;
    logic              fired;

    function automatic logic since_expiry_sign(input logic [TIME_W-1:0] t_now,
                                               input logic [TIME_W-1:0] t_due);
        logic [TIME_W-1:0] diff;
        diff = t_now - t_due;
        return diff[TIME_W-1];
    endfunction

    assign interval_ok  = (cfg.interval_ms != '0) && (cfg.interval_ms <= MaxIntervalMs);
    assign count_ok     = (cfg.repeat_count != '0) && (cfg.repeat_count <= MaxRepeats);
    assign due_from_now = item.now + TIME_W'(cfg.interval_ms);
    assign since_now    = item.now - state_cur.blocked_since;
    assign expired_cur  = ~since_expiry_sign(item.now, state_cur.due_time);
    assign enable_rise  = (cfg.mode == MODE_PERIODIC) && cfg.enable_linked
                          && item.enable && !state_cur.running;

    always_comb begin
        state_nxt    = state_cur;
        fired        = 1'b0;
        tick_pending = state_cur.pending;
        case (item.operation)
            OP_BLOCK: begin
                if (!state_cur.blocked) begin
                    state_nxt.blocked       = 1'b1;
                    state_nxt.blocked_since = item.now;
                end
            end
            OP_UNBLOCK: begin
                if (state_cur.blocked) begin
                    // shift the due time by the span spent blocked
                    if (state_cur.pending) begin
                        state_nxt.due_time = state_cur.due_time + since_now;
                    end
                    state_nxt.blocked = 1'b0;
                end
            end
            OP_TRIGGER: begin
                if (!state_cur.blocked && interval_ok) begin
                    case (cfg.mode)
                        MODE_COOLDOWN: begin
                            if (!state_cur.pending || expired_cur) begin
                                state_nxt.pending  = 1'b1;
                                state_nxt.due_time = due_from_now;
                                fired              = 1'b1;
                            end
                        end
                        MODE_REPEAT: begin
                            if (!state_cur.pending && count_ok) begin
                                state_nxt.remaining = REMAIN_W'(cfg.repeat_count - 1'b1);
                                state_nxt.pending   = cfg.repeat_count > COUNT_W'(1);
                                state_nxt.due_time  = due_from_now;
                                fired               = 1'b1;
                            end
                        end
                        MODE_PERIODIC: begin
                            state_nxt.running  = 1'b1;
                            state_nxt.pending  = 1'b1;
                            state_nxt.due_time = due_from_now;
                        end
                        default: begin
                            state_nxt.pending  = 1'b1;
                            state_nxt.due_time = due_from_now;
                        end
                    endcase
                end
            end
            OP_TICK: begin
                if (!state_cur.blocked) begin
                    if ((cfg.mode == MODE_PERIODIC) && cfg.enable_linked) begin
                        if (enable_rise) begin
                            tick_pending       = interval_ok;
                            state_nxt.due_time = interval_ok ? due_from_now : item.now;
                        end
                        if (!item.enable) begin
                            tick_pending = 1'b0;
                        end
                        state_nxt.running = item.enable;
                    end
                    state_nxt.pending = tick_pending;
                    // a fresh start is due a full interval ahead, so it cannot fire here
                    if (tick_pending && (cfg.mode != MODE_COOLDOWN)
                        && !enable_rise && expired_cur) begin
                        fired = 1'b1;
                        case (cfg.mode)
                            MODE_REPEAT: begin
                                if (state_cur.remaining <= REMAIN_W'(1)) begin
                                    state_nxt.remaining = '0;
                                    state_nxt.pending   = 1'b0;
                                end else begin
                                    state_nxt.remaining = state_cur.remaining - 1'b1;
                                    state_nxt.due_time  = due_from_now;
                                end
                            end
                            MODE_PERIODIC: begin
                                state_nxt.due_time = due_from_now;
                            end
                            default: begin
                                state_nxt.pending = 1'b0;
                            end
                        endcase
                    end
                end
            end
            default: begin
                state_nxt = state_cur;
            end
        endcase
    end

    assign result.fired        = fired;
    assign result.pending_now  = state_nxt.pending;
    assign result.left_to_fire = state_nxt.remaining;

endmodule

// ===== design/multi_mode_interval_timer_unit.sv =====
// An accepted beat goes through the input register, then the result register
// onto m_valid. Throughput: one item per cycle while m_ready does not stall;
// the single compute step between them updates the timer state register.
// Reset (aresetn low, synchronous): timer state and valid flags clear,
// configuration returns to mode delay, 1000 ms interval, repeat count 1.
module multi_mode_interval_timer_unit
    import mmit_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data
);

    cfg_t         cfg_reg;
    timer_state_t state_reg;
    timer_state_t state_next;
    in_item_t     in_data_reg;
    logic         in_valid_reg;
    out_item_t    out_data_reg;
    out_item_t    out_data_next;
    logic         out_valid_reg;
    logic         step;

    // advance the held beat when the result slot is free or being drained
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode          <= MODE_DELAY;
            cfg_reg.interval_ms   <= ResetIntervalMs;
            cfg_reg.repeat_count  <= COUNT_W'(1);
            cfg_reg.enable_linked <= 1'b0;
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_MODE:          cfg_reg.mode          <= mode_t'(cfg_wdata[1:0]);
                REG_INTERVAL_MS:   cfg_reg.interval_ms   <= cfg_wdata[INTERVAL_W-1:0];
                REG_REPEAT_COUNT:  cfg_reg.repeat_count  <= cfg_wdata[COUNT_W-1:0];
                REG_ENABLE_LINKED: cfg_reg.enable_linked <= cfg_wdata[0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    mmit_core u_core (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .item      (in_data_reg),
        .state_nxt (state_next),
        .result    (out_data_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (step) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTH
    a_state_holds_without_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(state_reg))
        else $error("timer state changed without an item");

    a_blocked_never_fires: assert property (@(posedge aclk) disable iff (!aresetn)
        step && state_reg.blocked
        && (in_data_reg.operation == OP_TRIGGER || in_data_reg.operation == OP_TICK)
        |=> !out_data_reg.fired)
        else $error("blocked timer fired");

    a_cooldown_tick_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (cfg_reg.mode == MODE_COOLDOWN) && (in_data_reg.operation == OP_TICK)
        |=> !out_data_reg.fired && (out_data_reg.pending_now == $past(state_reg.pending)))
        else $error("cooldown tick fired or dropped the armed window");

    a_result_follows_step: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid)
        else $error("result beat lost");
`endif

endmodule

// ===== tb/sv/multi_mode_interval_timer_unit_test.sv =====
module multi_mode_interval_timer_unit_test;
    import mmit_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUIET_LIMIT = 400;
    localparam int unsigned RANDOM_BEATS = 1300;

    typedef struct packed {
        logic       is_cfg;
        reg_index_t idx;
        logic [CFG_DATA_W-1:0] val;
        in_item_t   beat;
        logic       has_exp;
        out_item_t  exp;
    } stim_row_t;

    typedef struct packed {
        logic      has_exp;
        out_item_t val;
    } spelled_t;

    logic      aclk;
    logic      aresetn;
    logic      cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    cfg_t         tcfg;
    timer_state_t tstate;
    out_item_t    timer_outcomes_q[$];
    spelled_t     spelled_outcomes_q[$];
    stim_row_t    directed_rows[$];
    int unsigned  error_count;
    int unsigned  quiet_cycles;
    logic         steady;

    multi_mode_interval_timer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic interval_in_range();
        return tcfg.interval_ms >= 1 && tcfg.interval_ms <= MaxIntervalMs;
    endfunction

    // wrapping signed compare: due once now has reached due_time
    function automatic logic is_due(logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] d;
        d = now - tstate.due_time;
        return !d[TIME_W-1];
    endfunction

    function automatic out_item_t advance_timer(in_item_t b);
        logic      fired;
        logic [TIME_W-1:0] iv;
        out_item_t r;
        fired = 1'b0;
        iv = TIME_W'(tcfg.interval_ms);
        case (b.operation)
            OP_BLOCK: begin
                if (!tstate.blocked) begin
                    tstate.blocked = 1'b1;
                    tstate.blocked_since = b.now;
                end
            end
            OP_UNBLOCK: begin
                if (tstate.blocked) begin
                    // shift the schedule by the blocked span
                    if (tstate.pending)
                        tstate.due_time = tstate.due_time + (b.now - tstate.blocked_since);
                    tstate.blocked = 1'b0;
                end
            end
            OP_TRIGGER: begin
                if (!tstate.blocked && interval_in_range()) begin
                    case (tcfg.mode)
                        MODE_COOLDOWN: begin
                            if (!tstate.pending || is_due(b.now)) begin
                                tstate.pending = 1'b1;
                                tstate.due_time = b.now + iv;
                                fired = 1'b1;
                            end
                        end
                        MODE_REPEAT: begin
                            if (!tstate.pending && tcfg.repeat_count >= 1
                                    && tcfg.repeat_count <= MaxRepeats) begin
                                tstate.remaining = REMAIN_W'(tcfg.repeat_count - 1'b1);
                                tstate.pending = tcfg.repeat_count > 1;
                                tstate.due_time = b.now + iv;
                                fired = 1'b1;
                            end
                        end
                        default: begin
                            if (tcfg.mode == MODE_PERIODIC)
                                tstate.running = 1'b1;
                            tstate.pending = 1'b1;
                            tstate.due_time = b.now + iv;
                        end
                    endcase
                end
            end
            default: begin
                if (!tstate.blocked) begin
                    if (tcfg.mode == MODE_PERIODIC && tcfg.enable_linked) begin
                        if (b.enable && !tstate.running) begin
                            // rising level starts the timer; a bad interval leaves it idle
                            if (interval_in_range()) begin
                                tstate.pending = 1'b1;
                                tstate.due_time = b.now + iv;
                            end else begin
                                tstate.pending = 1'b0;
                                tstate.due_time = b.now;
                            end
                        end
                        if (!b.enable)
                            tstate.pending = 1'b0;
                        tstate.running = b.enable;
                    end
                    if (tstate.pending && tcfg.mode != MODE_COOLDOWN && is_due(b.now)) begin
                        fired = 1'b1;
                        case (tcfg.mode)
                            MODE_REPEAT: begin
                                if (tstate.remaining <= 1) begin
                                    tstate.remaining = '0;
                                    tstate.pending = 1'b0;
                                end else begin
                                    tstate.remaining = tstate.remaining - 1'b1;
                                    tstate.due_time = b.now + iv;
                                end
                            end
                            MODE_PERIODIC: tstate.due_time = b.now + iv;
                            default: tstate.pending = 1'b0;
                        endcase
                    end
                end
            end
        endcase
        r.fired = fired;
        r.pending_now = tstate.pending;
        r.left_to_fire = tstate.remaining;
        return r;
    endfunction

    function automatic void add_cfg(reg_index_t idx, logic [CFG_DATA_W-1:0] v);
        stim_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = v;
        directed_rows = {directed_rows, r};
    endfunction

    function automatic void add_beat(op_t op, logic [TIME_W-1:0] now, logic en,
                                     logic has_exp, logic f, logic p,
                                     logic [REMAIN_W-1:0] left);
        stim_row_t r;
        r = '0;
        r.beat.operation = op;
        r.beat.now = now;
        r.beat.enable = en;
        r.has_exp = has_exp;
        r.exp.fired = f;
        r.exp.pending_now = p;
        r.exp.left_to_fire = left;
        directed_rows = {directed_rows, r};
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            REG_MODE:          tcfg.mode = mode_t'(v[1:0]);
            REG_INTERVAL_MS:   tcfg.interval_ms = v[INTERVAL_W-1:0];
            REG_REPEAT_COUNT:  tcfg.repeat_count = v[COUNT_W-1:0];
            default:           tcfg.enable_linked = v[0];
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // drop valid and hold until every outstanding result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (timer_outcomes_q.size() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic send_beat(input in_item_t b, input logic has_exp, input out_item_t want);
        int unsigned gap;
        spelled_t s;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s.has_exp = has_exp;
        s.val = want;
        spelled_outcomes_q = {spelled_outcomes_q, s};
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin : watch_beats
        out_item_t predicted;
        out_item_t want;
        spelled_t  s;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted = advance_timer(s_data);
                s = spelled_outcomes_q.pop_front();
                timer_outcomes_q = {timer_outcomes_q, (s.has_exp ? s.val : predicted)};
            end
            if (m_valid && m_ready) begin
                if (timer_outcomes_q.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding", 32'(m_data), 0);
                end else begin
                    want = timer_outcomes_q.pop_front();
                    if (m_data.fired !== want.fired)
                        report_mismatch("fired", 32'(m_data.fired), 32'(want.fired));
                    if (m_data.pending_now !== want.pending_now)
                        report_mismatch("pending_now", 32'(m_data.pending_now),
                                        32'(want.pending_now));
                    if (m_data.left_to_fire !== want.left_to_fire)
                        report_mismatch("left_to_fire", 32'(m_data.left_to_fire),
                                        32'(want.left_to_fire));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin : sink
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned n;
        int unsigned k;
        int unsigned beats_counted;
        int unsigned span;
        int unsigned roll;
        logic [TIME_W-1:0] clock_ms;
        logic [CFG_DATA_W-1:0] cv;
        logic en_level;
        op_t op;
        in_item_t b;

        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_MODE;
        cfg_wdata = '0;
        aresetn = 1'b0;
        steady = 1'b0;
        error_count = 0;
        tcfg.mode = MODE_DELAY;
        tcfg.interval_ms = ResetIntervalMs;
        tcfg.repeat_count = COUNT_W'(1);
        tcfg.enable_linked = 1'b0;
        tstate = '0;

        // reset configuration: delay mode, 1000 ms
        add_beat(OP_TICK,    32'd0,          1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
        add_beat(OP_TRIGGER, 32'd0,          1'b0, 1'b1, 1'b0, 1'b1, 7'd0);
        add_beat(OP_TICK,    32'd999,        1'b1, 1'b1, 1'b0, 1'b1, 7'd0);
        add_beat(OP_TICK,    32'd1000,       1'b0, 1'b1, 1'b1, 1'b0, 7'd0);
        add_beat(OP_TICK,    32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0, 1'b0, 7'd0);
        // interval out of range on both sides
        add_cfg(REG_INTERVAL_MS, '0);
        add_beat(OP_TRIGGER, 32'd5,          1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
        add_cfg(REG_INTERVAL_MS, MaxIntervalMs + 1'b1);
        add_beat(OP_TRIGGER, 32'd5,          1'b1, 1'b1, 1'b0, 1'b0, 7'd0);
        // repeat count out of range, then a single-shot repeat
        add_cfg(REG_INTERVAL_MS, MaxIntervalMs);
        add_cfg(REG_MODE, CFG_DATA_W'(MODE_REPEAT));
        add_cfg(REG_REPEAT_COUNT, '0);
        add_beat(OP_TRIGGER, 32'd7,          1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
        add_cfg(REG_REPEAT_COUNT, CFG_DATA_W'(129));
        add_beat(OP_TRIGGER, 32'd7,          1'b0, 1'b1, 1'b0, 1'b0, 7'd0);
        add_cfg(REG_REPEAT_COUNT, CFG_DATA_W'(1));
        add_beat(OP_TRIGGER, 32'd10,         1'b0, 1'b1, 1'b1, 1'b0, 7'd0);
        // delay arms a firing, repeat mode then fires it with nothing left
        add_cfg(REG_MODE, CFG_DATA_W'(MODE_DELAY));
        add_cfg(REG_INTERVAL_MS, CFG_DATA_W'(1));
        add_beat(OP_TRIGGER, 32'd20,         1'b0, 1'b1, 1'b0, 1'b1, 7'd0);
        add_cfg(REG_MODE, CFG_DATA_W'(MODE_REPEAT));
        add_beat(OP_TICK,    32'd21,         1'b0, 1'b1, 1'b1, 1'b0, 7'd0);
        // full repeat count across the time wrap, with block and unblock
        add_cfg(REG_REPEAT_COUNT, CFG_DATA_W'(128));
        add_cfg(REG_INTERVAL_MS, MaxIntervalMs);
        add_beat(OP_TRIGGER, 32'hFFFF_FF00,  1'b0, 1'b1, 1'b1, 1'b1, 7'd127);
        add_beat(OP_TRIGGER, 32'hFFFF_FF01,  1'b0, 1'b1, 1'b0, 1'b1, 7'd127);
        add_beat(OP_BLOCK,   32'd100,        1'b0, 1'b1, 1'b0, 1'b1, 7'd127);
        add_beat(OP_TICK,    32'd0,          1'b1, 1'b1, 1'b0, 1'b1, 7'd127);
        add_beat(OP_BLOCK,   32'd200,        1'b0, 1'b1, 1'b0, 1'b1, 7'd127);
        add_beat(OP_UNBLOCK, 32'd300,        1'b0, 1'b1, 1'b0, 1'b1, 7'd127);
        add_beat(OP_UNBLOCK, 32'd400,        1'b0, 1'b1, 1'b0, 1'b1, 7'd127);
        add_beat(OP_TICK,    32'd86399943,   1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        add_beat(OP_TICK,    32'd86399944,   1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        // cooldown: armed window blocks triggers, ticks never fire
        add_cfg(REG_MODE, CFG_DATA_W'(MODE_COOLDOWN));
        add_cfg(REG_INTERVAL_MS, CFG_DATA_W'(1));
        add_beat(OP_TRIGGER, 32'd86399945,   1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        add_beat(OP_TICK,    32'h7FFF_FFFF,  1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
        add_beat(OP_TRIGGER, 32'h8000_0000,  1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
        // periodic timer following the enable level, bad interval first
        add_cfg(REG_MODE, CFG_DATA_W'(MODE_PERIODIC));
        add_cfg(REG_ENABLE_LINKED, CFG_DATA_W'(1));
        add_cfg(REG_INTERVAL_MS, '0);
        add_beat(OP_TICK,    32'd2,          1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
        add_cfg(REG_INTERVAL_MS, CFG_DATA_W'(3));
        add_beat(OP_TICK,    32'd3,          1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        add_beat(OP_TICK,    32'd4,          1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
        add_beat(OP_TICK,    32'd7,          1'b1, 1'b0, 1'b0, 1'b0, 7'd0);
        add_cfg(REG_ENABLE_LINKED, '0);
        add_beat(OP_TRIGGER, 32'd10,         1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
        add_beat(OP_TICK,    32'd13,         1'b0, 1'b0, 1'b0, 1'b0, 7'd0);

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                drain_results();
                write_reg(directed_rows[i].idx, directed_rows[i].val);
            end else begin
                send_beat(directed_rows[i].beat, directed_rows[i].has_exp,
                          directed_rows[i].exp);
            end
        end

        beats_counted = 0;
        en_level = 1'b0;
        for (phase = 0; beats_counted < RANDOM_BEATS; phase++) begin
            drain_results();
            steady = (phase % 5 == 4);
            if ($urandom_range(0, 3) == 0)
                cv = CFG_DATA_W'($urandom_range(0, 3));
            else
                cv = CFG_DATA_W'(phase % 4);
            write_reg(REG_MODE, cv);
            case (phase % 8)
                0:       cv = CFG_DATA_W'(1);
                1:       cv = MaxIntervalMs;
                2:       cv = CFG_DATA_W'($urandom);
                3:       cv = CFG_DATA_W'($urandom_range(2, 500));
                default: cv = CFG_DATA_W'($urandom_range(1, 40));
            endcase
            write_reg(REG_INTERVAL_MS, cv);
            case (phase % 6)
                0:       cv = CFG_DATA_W'(1);
                1:       cv = CFG_DATA_W'(128);
                2:       cv = CFG_DATA_W'($urandom_range(0, 255));
                default: cv = CFG_DATA_W'($urandom_range(2, 8));
            endcase
            write_reg(REG_REPEAT_COUNT, cv);
            write_reg(REG_ENABLE_LINKED, CFG_DATA_W'($urandom_range(0, 1)));

            span = interval_in_range() ? int'(tcfg.interval_ms) : 20;
            if ($urandom_range(0, 3) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * span);
            else
                clock_ms = $urandom;
            n = $urandom_range(50, 110);
            for (k = 0; k < n; k++) begin
                roll = $urandom_range(0, 99);
                if (tstate.blocked) begin
                    op = roll < 45 ? OP_UNBLOCK : roll < 60 ? OP_BLOCK :
                         roll < 80 ? OP_TICK : OP_TRIGGER;
                end else begin
                    op = roll < 62 ? OP_TICK : roll < 84 ? OP_TRIGGER :
                         roll < 93 ? OP_BLOCK : OP_UNBLOCK;
                end
                beats_counted++;
                // mostly advance time in steps near the interval, now and then jump anywhere
                if ($urandom_range(0, 19) == 0) begin
                    b.now = $urandom;
                end else begin
                    clock_ms = clock_ms + $urandom_range(0, span + span / 2);
                    b.now = clock_ms;
                end
                if ($urandom_range(0, 6) == 0)
                    en_level = ~en_level;
                b.operation = op;
                b.enable = (op == OP_TICK) ? en_level : 1'($urandom_range(0, 1));
                send_beat(b, 1'b0, '0);
            end
        end

        drain_results();
        repeat (5) @(negedge aclk);
        if (timer_outcomes_q.size() != 0)
            report_mismatch("results never delivered", 32'(timer_outcomes_q.size()), 0);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
